/* rtl/core/tprl_pkg.sv */
// Package for the two-pole resonant lowpass unit.
// Holds the configuration register index codes; no dependencies.
`timescale 1ns / 1ps

package tprl_pkg;

  localparam int CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COEF_ONE = 1'b0,
    CFG_COEF_TWO = 1'b1
  } cfg_index_t;

endpackage

/* rtl/core/tprl_in_if.sv */
// Input sample channel of the two-pole resonant lowpass unit.
// Valid/ready handshake carrying one signed sample; no dependencies.
`timescale 1ns / 1ps

interface tprl_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

/* rtl/core/tprl_out_if.sv */
// Result channel of the two-pole resonant lowpass unit.
// Valid/ready handshake carrying the filtered sample and its clip flag.
`timescale 1ns / 1ps

interface tprl_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

/* rtl/core/tprl_recur.sv */
// Feedback stage: subtracts the two feedback products from the scaled input,
// rounds, saturates and shifts the output history. No package dependency.
`timescale 1ns / 1ps

module tprl_recur #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        load,
  input  logic signed [COEF_FRAC_BITS+SAMPLE_BITS+2:0] px,
  input  logic signed [COEF_FRAC_BITS+1:0]            coef_one,
  input  logic        [COEF_FRAC_BITS-1:0]            coef_two,
  output logic signed [SAMPLE_BITS-1:0]               y_out,
  output logic                                        clip_out
);

  localparam int SW    = SAMPLE_BITS;
  localparam int F     = COEF_FRAC_BITS;
  localparam int P1_W  = F + 2 + SW;
  localparam int P2_W  = F + 1 + SW;
  localparam int ACC_W = SW + F + 5;
  localparam int RW    = ACC_W - F;

  logic signed [SW-1:0]    y1;
  logic signed [SW-1:0]    y2;
  logic                    clip;
  logic signed [P1_W-1:0]  p1;
  logic signed [P2_W-1:0]  p2;
  logic signed [ACC_W-1:0] acc;
  logic signed [RW-1:0]    rnd;
  logic                    ovf;
  logic signed [SW-1:0]    y_next;

  assign p1 = P1_W'(coef_one) * P1_W'(y1);
  assign p2 = P2_W'($signed({1'b0, coef_two})) * P2_W'(y2);

  // round half up: add half an LSB, then floor through the arithmetic shift
  assign acc = ACC_W'(px) - ACC_W'(p1) - ACC_W'(p2)
             + (ACC_W'(1) <<< (F - 1));
  assign rnd = $signed(acc[ACC_W-1:F]);

  // out of range when the bits above the sample sign differ from it
  assign ovf = !((&rnd[RW-1:SW-1]) || !(|rnd[RW-1:SW-1]));

  always_comb begin
    if (!ovf) begin
      y_next = rnd[SW-1:0];
    end else if (rnd[RW-1]) begin
      y_next = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y_next = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y1   <= '0;
      y2   <= '0;
      clip <= 1'b0;
    end else if (load) begin
      y2   <= y1;
      y1   <= y_next;
      clip <= ovf;
    end
  end

  assign y_out    = y1;
  assign clip_out = clip;

`ifndef ASSERT_OFF
  a_history_shift: assert property (@(posedge clk) disable iff (rst)
    load |=> (y2 == $past(y1)))
    else $error("output history did not shift on load");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    clip |-> ((y1 == {1'b1, {(SW-1){1'b0}}}) || (y1 == {1'b0, {(SW-1){1'b1}}})))
    else $error("clip flag set on a sample that is not at a rail");
`endif

endmodule

/* rtl/core/two_pole_resonant_lowpass_unit.sv */
// Two-pole resonant lowpass unit: all-pole biquad with unity DC gain.
// Depends on tprl_pkg, tprl_in_if, tprl_out_if and tprl_recur.
//
// Usage:
//   din  carries one signed Q1.(SAMPLE_BITS-1) sample per transfer.
//   dout carries the filtered, saturated sample and a clipped flag.
//   wr_en/wr_index/wr_data write the coefficients: index CFG_COEF_ONE
//   takes a1 (signed Q2.COEF_FRAC_BITS), index CFG_COEF_TWO takes a2
//   (unsigned Q0.COEF_FRAC_BITS). Write only while no sample is in flight.
// Timing:
//   A sample accepted on din is registered as scale*x in the input stage,
//   then loaded into the feedback stage, whose y1 register drives dout.
//   One sample per cycle is sustained while dout is not stalled: the input
//   stage forms scale*x; the feedback stage closes y1/y2 through its two
//   feedback multipliers, which sets the clock rate of the block.
// Reset clears both coefficients, the output history and both valid flags.
// When dout stalls the result is held; one more sample may wait in the
// input stage, after which din.ready drops until the result is taken.
`timescale 1ns / 1ps

module two_pole_resonant_lowpass_unit #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [tprl_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [COEF_FRAC_BITS+1:0]          wr_data,
  tprl_in_if.sink                            din,
  tprl_out_if.source                         dout
);

  localparam int SW      = SAMPLE_BITS;
  localparam int F       = COEF_FRAC_BITS;
  localparam int CW      = F + 2;
  localparam int SCALE_W = F + 3;
  localparam int PX_W    = SCALE_W + SW;

  logic signed [CW-1:0]      coef_one;
  logic        [F-1:0]       coef_two;
  logic signed [SCALE_W-1:0] scale;
  logic signed [PX_W-1:0]    px_next;
  logic signed [PX_W-1:0]    px;
  logic                      s1_valid;
  logic                      out_valid;
  logic                      advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_one <= '0;
      coef_two <= '0;
    end else if (wr_en) begin
      unique case (tprl_pkg::cfg_index_t'(wr_index))
        tprl_pkg::CFG_COEF_ONE: coef_one <= $signed(wr_data);
        tprl_pkg::CFG_COEF_TWO: coef_two <= wr_data[F-1:0];
        default: ;
      endcase
    end
  end

  // scale = 1 + a1 + a2, exact at SCALE_W bits
  assign scale = $signed((SCALE_W'(1) << F) + SCALE_W'(coef_one)
                         + SCALE_W'({1'b0, coef_two}));
  assign px_next = PX_W'(scale) * PX_W'(din.sample_in);

  assign advance   = s1_valid && (!out_valid || dout.ready);
  assign din.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (din.ready) begin
        s1_valid <= din.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the scaled input until the feedback stage takes it
  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      px <= px_next;
    end
  end

  tprl_recur #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_recur (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .px       (px),
    .coef_one (coef_one),
    .coef_two (coef_two),
    .y_out    (dout.sample_out),
    .clip_out (dout.clipped)
  );

  assign dout.valid = out_valid;

`ifndef ASSERT_OFF
  a_stall_blocks_intake: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !dout.ready) |-> !din.ready)
    else $error("input taken while both stages are held");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("feedback stage loaded without presenting a result");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid))
    else $error("valid flags not cleared by reset");
`endif

endmodule
